>>> sv/burst_events_to_step_segments_unit_macros.svh
// Assertion macros for the burst-to-segment converter checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef BURST_EVENTS_TO_STEP_SEGMENTS_UNIT_MACROS_SVH
`define BURST_EVENTS_TO_STEP_SEGMENTS_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define BES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bes_pkg.sv
// Shared constants and types for the burst-to-segment converter.
// No dependencies; used by every RTL module of the block.
package bes_pkg;

  // Number of threads tracked and the width of a thread index
  localparam int THREADS = 64;
  localparam int IDX_W   = (THREADS > 1) ? $clog2(THREADS) : 1;

  // Field widths
  localparam int KIND_W  = 8;
  localparam int STATE_W = 8;
  localparam int TNUM_W  = 7;
  localparam int TIME_W  = 48;
  localparam int LEN_W   = TIME_W + 1;
  localparam int SEGT_W  = 6;

  // Record codes that are processed
  localparam logic [KIND_W-1:0]  KIND_STATE    = 8'd1;
  localparam logic [STATE_W-1:0] STATE_RUNNING = 8'd1;

  // Requests from the sequencer to the per-thread state store
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [TIME_W-1:0] wr_end;
    logic [IDX_W-1:0]  look_idx;
  } st_req_t;

  // State seen by the item in the work register
  typedef struct packed {
    logic              started;
    logic [TIME_W-1:0] last_end;
  } st_rsp_t;

endpackage

>>> sv/burst_events_to_step_segments_unit.sv
// Burst-to-step-segment converter, top level with stream ports.
// Depends on bes_pkg, bes_state and bes_seq.
//
// Takes trace records and turns each running-state burst (record kind 1, state 1,
// thread 1..64) into step segments for that thread: an idle segment (value 0)
// from the thread's last segment end (0 for its first burst) up to the burst
// start, then, if the burst end lies after its start, a burst segment whose
// value is its duration; tlast marks the last segment of a record. Idle lengths
// are signed and go negative when records arrive out of order. Other records
// are taken and dropped without entering the work register. A record holds the
// work register until its last segment is loaded into the single result
// register, which takes one segment per cycle while the output does not stall.
// A new record is taken in the cycle its predecessor hands over its last
// segment. There is no clearing pass after reset.
module burst_events_to_step_segments_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [6:0] thread_number, [54:7] burst_start, [102:55] burst_end, [103] zero
  input  logic [103:0] s_axis_tdata,
  // [7:0] record_kind, [15:8] state_code
  input  logic [15:0]  s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [5:0] seg_thread, [53:6] seg_start, [102:54] seg_length, [150:103] seg_value,
  // [151] zero
  output logic [151:0] m_axis_tdata,
  // seg_last
  output logic         m_axis_tlast
);

  bes_pkg::st_req_t st_req;
  bes_pkg::st_rsp_t st_rsp;

  logic [bes_pkg::SEGT_W-1:0]          seg_thread;
  logic [bes_pkg::TIME_W-1:0]          seg_start;
  logic signed [bes_pkg::LEN_W-1:0]    seg_length;
  logic [bes_pkg::TIME_W-1:0]          seg_value;

  // Filter, sequencer and result register
  bes_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .kind_i       (s_axis_tuser[7:0]),
    .state_i      (s_axis_tuser[15:8]),
    .tnum_i       (s_axis_tdata[6:0]),
    .t0_i         (s_axis_tdata[54:7]),
    .t1_i         (s_axis_tdata[102:55]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .seg_thread_o (seg_thread),
    .seg_start_o  (seg_start),
    .seg_length_o (seg_length),
    .seg_value_o  (seg_value),
    .seg_last_o   (m_axis_tlast),
    .st_req_o     (st_req),
    .st_rsp_i     (st_rsp)
  );

  // Per-thread state
  bes_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (st_req),
    .rsp_o  (st_rsp)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata = {1'b0, seg_value, seg_length, seg_start, seg_thread};

endmodule

>>> sv/bes_state.sv
// Per-thread state: started flags in flip-flops, last segment end in a memory.
// Depends on bes_pkg.
module bes_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bes_pkg::st_req_t req_i,
  output bes_pkg::st_rsp_t rsp_o
);

  logic [bes_pkg::THREADS-1:0] started_q;
  logic [bes_pkg::TIME_W-1:0]  end_mem [bes_pkg::THREADS];
  logic [bes_pkg::TIME_W-1:0]  rd_q;
  logic                        byp_q;
  logic [bes_pkg::TIME_W-1:0]  byp_end_q;

  // Started flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= '0;
    end else if (req_i.wr_en) begin
      started_q[req_i.wr_idx] <= 1'b1;
    end
  end

  // Last segment end store, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      end_mem[req_i.wr_idx] <= req_i.wr_end;
    end
    if (req_i.rd_en) begin
      rd_q <= end_mem[req_i.rd_idx];
    end
  end

  // Forward a write that lands on the same edge as the read of the same thread
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (req_i.rd_en) begin
      byp_q <= req_i.wr_en && (req_i.wr_idx == req_i.rd_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      byp_end_q <= req_i.wr_end;
    end
  end

  assign rsp_o.started  = started_q[req_i.look_idx];
  assign rsp_o.last_end = byp_q ? byp_end_q : rd_q;

endmodule

>>> sv/bes_seq.sv
// Record filter, work register and segment sequencer with the result register.
// Depends on bes_pkg; drives the requests of bes_state.
module bes_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bes_pkg::KIND_W-1:0]    kind_i,
  input  logic [bes_pkg::STATE_W-1:0]   state_i,
  input  logic [bes_pkg::TNUM_W-1:0]    tnum_i,
  input  logic [bes_pkg::TIME_W-1:0]    t0_i,
  input  logic [bes_pkg::TIME_W-1:0]    t1_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bes_pkg::SEGT_W-1:0]    seg_thread_o,
  output logic [bes_pkg::TIME_W-1:0]    seg_start_o,
  output logic signed [bes_pkg::LEN_W-1:0] seg_length_o,
  output logic [bes_pkg::TIME_W-1:0]    seg_value_o,
  output logic                          seg_last_o,
  output bes_pkg::st_req_t              st_req_o,
  input  bes_pkg::st_rsp_t              st_rsp_i
);

  // Work register
  logic                       s1_vld_q, s1_vld_d;
  logic                       ph_q, ph_d;
  logic [bes_pkg::IDX_W-1:0]  s1_idx_q;
  logic [bes_pkg::TIME_W-1:0] s1_t0_q, s1_t1_q;

  // Result register
  logic                       out_vld_q, out_vld_d;
  logic [bes_pkg::SEGT_W-1:0] out_thr_q;
  logic [bes_pkg::TIME_W-1:0] out_start_q;
  logic [bes_pkg::LEN_W-1:0]  out_len_q;
  logic [bes_pkg::TIME_W-1:0] out_val_q;
  logic                       out_last_q;

  logic                       pass, in_acc, in_take;
  logic [bes_pkg::IDX_W-1:0]  in_idx;
  logic                       out_free, load, done, burst;
  logic [bes_pkg::TIME_W-1:0] from, op_a, op_b;
  logic [bes_pkg::LEN_W-1:0]  diff;

  // Only running-state records of a valid thread enter the work register
  assign pass = (kind_i == bes_pkg::KIND_STATE) && (state_i == bes_pkg::STATE_RUNNING) &&
                (tnum_i != '0) && (32'(tnum_i) <= bes_pkg::THREADS);
  assign in_idx  = bes_pkg::IDX_W'(tnum_i - 1'b1);
  assign in_acc  = in_valid_i && in_ready_o;
  assign in_take = in_acc && pass;

  // Segment sequencing: idle segment first, then the burst segment if any
  assign burst    = s1_t1_q > s1_t0_q;
  assign out_free = !out_vld_q || out_ready_i;
  assign load     = s1_vld_q && out_free;
  assign done     = load && (ph_q || !burst);
  assign in_ready_o = !s1_vld_q || done;

  // One subtractor serves both segment kinds
  assign from = st_rsp_i.started ? st_rsp_i.last_end : '0;
  assign op_a = ph_q ? s1_t1_q : s1_t0_q;
  assign op_b = ph_q ? s1_t0_q : from;
  assign diff = {1'b0, op_a} - {1'b0, op_b};

  always_comb begin
    s1_vld_d = s1_vld_q;
    ph_d     = ph_q;
    if (load) begin
      ph_d = ph_q ? 1'b0 : burst;
    end
    if (in_ready_o) begin
      s1_vld_d = in_take;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      ph_q     <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      ph_q     <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_idx_q <= in_idx;
      s1_t0_q  <= t0_i;
      s1_t1_q  <= t1_i;
    end
  end

  // Result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_thr_q   <= bes_pkg::SEGT_W'(s1_idx_q);
      out_start_q <= ph_q ? s1_t0_q : from;
      out_len_q   <= diff;
      out_val_q   <= ph_q ? diff[bes_pkg::TIME_W-1:0] : '0;
      out_last_q  <= ph_q || !burst;
    end
  end

  // State store requests: read on entry, update when the record finishes
  always_comb begin
    st_req_o.rd_en    = in_take;
    st_req_o.rd_idx   = in_idx;
    st_req_o.wr_en    = done;
    st_req_o.wr_idx   = s1_idx_q;
    st_req_o.wr_end   = burst ? s1_t1_q : s1_t0_q;
    st_req_o.look_idx = s1_idx_q;
  end

  assign out_valid_o  = out_vld_q;
  assign seg_thread_o = out_thr_q;
  assign seg_start_o  = out_start_q;
  assign seg_length_o = out_len_q;
  assign seg_value_o  = out_val_q;
  assign seg_last_o   = out_last_q;

endmodule

>>> sv/bes_checker.sv
// Port-level checker for the burst-to-segment converter, bound to the top level.
// Depends on burst_events_to_step_segments_unit_macros.svh.
`include "burst_events_to_step_segments_unit_macros.svh"

module bes_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [103:0] s_axis_tdata,
  input logic [15:0]  s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [151:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  logic [5:0]  thr;
  logic [48:0] len;
  logic [47:0] val;
  logic        m_acc;

  assign thr   = m_axis_tdata[5:0];
  assign len   = m_axis_tdata[102:54];
  assign val   = m_axis_tdata[150:103];
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // A stalled segment holds
  `BES_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled segment changed")

  // An idle segment that is not last always carries value zero
  `BES_ASSERT_NOW(a_idle_zero, m_axis_tvalid && !m_axis_tlast, val == '0, "idle segment with nonzero value")

  // A burst segment follows its idle segment at once, same thread
  `BES_ASSERT_NEXT(a_burst_follows, m_acc && !m_axis_tlast, m_axis_tvalid && m_axis_tlast && (thr == $past(thr)) && (val != '0), "burst segment missing after idle")

  // A burst segment's length equals its value
  `BES_ASSERT_NOW(a_burst_len, m_axis_tvalid && (val != '0), len == {1'b0, val}, "burst length and value disagree")

endmodule

bind burst_events_to_step_segments_unit bes_checker u_bes_checker (.*);

>>> verif/burst_events_to_step_segments_unit_test.sv
// Self-checking testbench for burst_events_to_step_segments_unit.
// Depends on bes_pkg and the unit itself; it predicts the segments of each burst record.
`timescale 1ns / 100ps

module burst_events_to_step_segments_unit_test;

  localparam int RANDOM_ITEMS   = 1300;
  localparam int CALM_ITEMS     = 150;   // tail of the run with no idling on either side
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam logic [bes_pkg::TIME_W-1:0] TIME_MAX = '1;

  // One trace record as presented on the slave side
  typedef struct packed {
    logic [bes_pkg::KIND_W-1:0]  kind;
    logic [bes_pkg::STATE_W-1:0] state;
    logic [bes_pkg::TNUM_W-1:0]  tnum;
    logic [bes_pkg::TIME_W-1:0]  t0;
    logic [bes_pkg::TIME_W-1:0]  t1;
  } burst_rec_t;

  // One step segment as seen on the master side
  typedef struct packed {
    logic [bes_pkg::SEGT_W-1:0]       thread;
    logic [bes_pkg::TIME_W-1:0]       start;
    logic signed [bes_pkg::LEN_W-1:0] length;
    logic [bes_pkg::TIME_W-1:0]       level;
    logic                             last;
  } step_seg_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [15:0]  s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [151:0] m_axis_tdata;
  logic         m_axis_tlast;

  burst_events_to_step_segments_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 0;
  end

  burst_rec_t        pending_records[$];
  step_seg_t         expected_segments[$];
  burst_rec_t        record_on_bus;
  int                error_count = 0;
  int                send_gap = 0;
  int                stall_left = 0;
  int                quiet_cycles = 0;

  // Predictor copy of the per-thread state
  logic                          thread_seen [bes_pkg::THREADS];
  logic [bes_pkg::TIME_W-1:0]    thread_end  [bes_pkg::THREADS];

  // Generator's idea of where each thread's timeline stands (guidance only)
  logic [bes_pkg::TIME_W-1:0] gen_cursor [bes_pkg::THREADS + 1];

  function automatic logic [bes_pkg::TIME_W-1:0] rand_time();
    return bes_pkg::TIME_W'({$urandom, $urandom});
  endfunction

  // Expected segments for one accepted record; updates the thread state
  task automatic predict_segments(input burst_rec_t rec);
    logic [bes_pkg::IDX_W-1:0]  idx;
    logic [bes_pkg::TIME_W-1:0] from;
    logic                       burst;
    step_seg_t                  seg;
    if (rec.kind != bes_pkg::KIND_STATE || rec.state != bes_pkg::STATE_RUNNING) return;
    if (rec.tnum == 0 || rec.tnum > bes_pkg::THREADS) return;
    idx   = bes_pkg::IDX_W'(rec.tnum - 1);
    from  = thread_seen[idx] ? thread_end[idx] : '0;
    burst = rec.t1 > rec.t0;
    // idle stretch up to the burst start, may go negative
    seg.thread = bes_pkg::SEGT_W'(idx);
    seg.start  = from;
    seg.length = {1'b0, rec.t0} - {1'b0, from};
    seg.level  = '0;
    seg.last   = !burst;
    expected_segments.push_back(seg);
    if (burst) begin
      seg.start  = rec.t0;
      seg.length = {1'b0, rec.t1 - rec.t0};
      seg.level  = rec.t1 - rec.t0;
      seg.last   = 1'b1;
      expected_segments.push_back(seg);
    end
    thread_seen[idx] = 1'b1;
    thread_end[idx]  = burst ? rec.t1 : rec.t0;
  endtask

  task automatic push_record(input logic [bes_pkg::KIND_W-1:0] kind,
                             input logic [bes_pkg::STATE_W-1:0] state,
                             input logic [bes_pkg::TNUM_W-1:0] tnum,
                             input logic [bes_pkg::TIME_W-1:0] t0,
                             input logic [bes_pkg::TIME_W-1:0] t1);
    burst_rec_t rec;
    rec = '{kind: kind, state: state, tnum: tnum, t0: t0, t1: t1};
    pending_records.push_back(rec);
    if (kind == bes_pkg::KIND_STATE && state == bes_pkg::STATE_RUNNING &&
        tnum >= 1 && tnum <= bes_pkg::THREADS)
      gen_cursor[tnum] = (t1 > t0) ? t1 : t0;
  endtask

  // Edge cases: first bursts, empty and inverted bursts, order reversal,
  // out-of-range threads, foreign kinds and states, field extremes
  task automatic fill_directed();
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd1, 48'd100, 48'd250);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd1, 48'd300, 48'd300);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd1, 48'd320, 48'd310);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd1, 48'd200, 48'd400);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd64, TIME_MAX, TIME_MAX);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd64, 48'd0, TIME_MAX);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd64, TIME_MAX, 48'd0);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd2, 48'd0, 48'd0);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd0, 48'd10, 48'd20);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd65, 48'd10, 48'd20);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd127, TIME_MAX, TIME_MAX);
    push_record(8'd0, bes_pkg::STATE_RUNNING, 7'd3, 48'd10, 48'd20);
    push_record(8'd255, bes_pkg::STATE_RUNNING, 7'd3, 48'd10, 48'd20);
    push_record(bes_pkg::KIND_STATE, 8'd0, 7'd3, 48'd10, 48'd20);
    push_record(bes_pkg::KIND_STATE, 8'd255, 7'd3, 48'd10, 48'd20);
    push_record(8'd2, 8'd2, 7'd3, 48'd10, 48'd20);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd3, 48'd5, TIME_MAX);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd32,
                48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd32,
                48'h0000_0000_0001, 48'h8000_0000_0000);
    push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, 7'd2, 48'd1, 48'd2);
  endtask

  // Mostly well-formed per-thread timelines, plus reversals, wide values and noise
  task automatic fill_random(input int count);
    int unsigned                pick;
    int unsigned                dur_kind;
    logic [bes_pkg::TNUM_W-1:0] th;
    logic [bes_pkg::TIME_W-1:0] t0;
    logic [bes_pkg::TIME_W-1:0] t1;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      th = $urandom_range(0, 1) ? bes_pkg::TNUM_W'($urandom_range(1, 4))
                                : bes_pkg::TNUM_W'($urandom_range(1, bes_pkg::THREADS));
      if (pick < 8) begin
        push_record(bes_pkg::KIND_W'($urandom), bes_pkg::STATE_W'($urandom),
                    bes_pkg::TNUM_W'($urandom), rand_time(), rand_time());
      end else if (pick < 12) begin
        th = $urandom_range(0, 3) == 0 ? '0
             : bes_pkg::TNUM_W'($urandom_range(bes_pkg::THREADS + 1, 127));
        push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, th, rand_time(),
                    rand_time());
      end else if (pick < 15) begin
        push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_W'($urandom), th, rand_time(),
                    rand_time());
      end else if (pick < 30) begin
        push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, th, rand_time(),
                    rand_time());
      end else begin
        if (pick < 38) t0 = gen_cursor[th] - bes_pkg::TIME_W'($urandom_range(1, 5000));
        else t0 = gen_cursor[th] + bes_pkg::TIME_W'($urandom_range(0, 1000));
        dur_kind = $urandom_range(0, 9);
        if (dur_kind == 0) t1 = t0;
        else if (dur_kind == 1) t1 = t0 - bes_pkg::TIME_W'($urandom_range(1, 100));
        else t1 = t0 + bes_pkg::TIME_W'($urandom_range(1, 5000));
        push_record(bes_pkg::KIND_STATE, bes_pkg::STATE_RUNNING, th, t0, t1);
      end
    end
  endtask

  // Record driver: holds each request until taken, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_segments(record_on_bus);
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the current request
      end else if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_records.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
        send_gap      <= $urandom_range(0, 11);
        s_axis_tvalid <= 1'b0;
      end else if (pending_records.size() != 0) begin
        record_on_bus = pending_records.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, record_on_bus.t1, record_on_bus.t0, record_on_bus.tnum};
        s_axis_tuser  <= {record_on_bus.state, record_on_bus.kind};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Segment monitor: compares each taken segment with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    step_seg_t got;
    step_seg_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.thread = m_axis_tdata[5:0];
        got.start  = m_axis_tdata[53:6];
        got.length = m_axis_tdata[102:54];
        got.level  = m_axis_tdata[150:103];
        got.last   = m_axis_tlast;
        if (expected_segments.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= 10)
            $display("%0t: unexpected segment thread %0d start %0d len %0d value %0d last %0b",
                     $realtime, got.thread, got.start, got.length, got.level, got.last);
        end else begin
          want = expected_segments.pop_front();
          if (got !== want) begin
            error_count = error_count + 1;
            if (error_count <= 10) begin
              $display("%0t: segment mismatch", $realtime);
              $display("  expected thread %0d start %0d len %0d value %0d last %0b",
                       want.thread, want.start, want.length, want.level, want.last);
              $display("  actual   thread %0d start %0d len %0d value %0d last %0b",
                       got.thread, got.start, got.length, got.level, got.last);
            end
          end
        end
      end
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (pending_records.size() > CALM_ITEMS && $urandom_range(0, 5) == 0) begin
        stall_left    <= $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any request taken on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int t = 0; t < bes_pkg::THREADS; t++) begin
      thread_seen[t] = 1'b0;
      thread_end[t]  = '0;
    end
    for (int t = 0; t <= bes_pkg::THREADS; t++) gen_cursor[t] = '0;
    fill_directed();
    fill_random(RANDOM_ITEMS);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain stimulus, then the outstanding segments, then let the pipe settle
    while (pending_records.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_segments.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/bes_pkg.sv
sv/bes_state.sv
sv/bes_seq.sv
sv/burst_events_to_step_segments_unit.sv
sv/bes_checker.sv
verif/burst_events_to_step_segments_unit_test.sv
